>>> src/ijust_pkg.sv
// ----------------------------------------------------------------------------
// ijust_pkg: shared types, constants and helpers for interval justification
// Fold factors, overflow limits and reciprocals for the constant dividers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ijust_pkg;

	typedef enum logic [1:0] {
		ACT_HOURS = 2'd0,
		ACT_DAYS  = 2'd1,
		ACT_FULL  = 2'd2,
		ACT_PASS  = 2'd3
	} action_t;

	typedef struct packed {
		logic [63:0] months;
		logic [63:0] days;
		logic [63:0] nanos;
	} ivl_t;

	typedef struct packed {
		logic [15:0] quo;
		logic [4:0]  rem;
	} div30_t;

	localparam logic [63:0] INT_MAX    = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] DAY_NS     = 64'd86400000000000;
	localparam logic [4:0]  MONTH_DAYS = 5'd30;
	localparam int unsigned DAY_SHIFT  = 16;

	// odd part of a day in ns, the low bits are a plain shift
	localparam logic signed [31:0] DAY_K   = 32'(DAY_NS >> DAY_SHIFT);
	localparam logic signed [37:0] MONTH_K = 38'(64'(MONTH_DAYS) * (DAY_NS >> DAY_SHIFT));

	// largest magnitudes that survive each fold multiply
	localparam logic signed [63:0] DAY_LIM   = INT_MAX / DAY_NS;
	localparam logic signed [63:0] MONTH_LIM = INT_MAX / (64'(MONTH_DAYS) * DAY_NS);
	localparam logic signed [63:0] M30_LIM   = INT_MAX / 64'(MONTH_DAYS);

	// floor reciprocals, the estimates they give are low by at most one
	localparam logic [19:0] DAY_RECIP = 20'((64'd1 << 50) / 64'(DAY_K));
	localparam logic [20:0] M30_RECIP = 21'((64'd1 << 25) / 64'(MONTH_DAYS));

	// one long-division digit by thirty, v below thirty times 2^16
	function automatic div30_t div30(input logic [20:0] v);
		logic [41:0] prod;
		logic [15:0] qe;
		logic [20:0] back;
		logic [5:0]  rr;
		div30_t      res;
		prod = 42'(v) * 42'(M30_RECIP);
		qe   = prod[40:25];
		back = 21'(qe) * 21'(MONTH_DAYS);
		rr   = 6'(v - back);
		if (rr >= 6'(MONTH_DAYS)) begin
			res.quo = qe + 16'd1;
			res.rem = 5'(rr - 6'(MONTH_DAYS));
		end else begin
			res.quo = qe;
			res.rem = rr[4:0];
		end
		return res;
	endfunction

endpackage

>>> src/interval_justify_unit.sv
// ----------------------------------------------------------------------------
// interval_justify_unit: months/days/nanos interval normalizer, 9-stage pipe
// One item accepted every cycle while no stalled result waits at the output.
// Rate is set by the pipe itself; out_stall on a waiting result holds all stages.
// arst_n clears the stage valid bits only; data registers are not reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module interval_justify_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         action,
	input  logic signed [63:0] in_months,
	input  logic signed [63:0] in_days,
	input  logic signed [63:0] in_nanos,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [63:0] out_months,
	output logic signed [63:0] out_days,
	output logic signed [63:0] out_nanos,
	output logic               range_error
);

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;

	ijust_pkg::action_t act_s1, act_s2, act_s3, act_s4, act_s5, act_s6, act_s7, act_s8;
	ijust_pkg::ivl_t    ivl_s1, ivl_s2, ivl_s3, ivl_s4, ivl_s5, ivl_s6, ivl_s7, ivl_s8;
	logic               err_s1, err_s2, err_s3, err_s4, err_s5, err_s6, err_s7, err_s8;
	logic               neg_s4, neg_s5, neg_s6, neg_s7, neg_s8;

	logic [63:0] dprod_s1, mprod_s1, sum_s2, t_s3, mag_s4, mag_s5;
	logic [16:0] qe_s5, qd_s6, qd_s7;
	logic [31:0] rem_s6, lo_s6;
	logic [30:0] nrem_s7;
	logic [15:0] lo_s7;
	ijust_pkg::div30_t c3_s5, c3_s6, c3_s7, c2_s6, c2_s7, c1_s7;
	logic [63:0] mmag_s8, dmag_s8, nmag_s8;
	logic [63:0] om_s9, od_s9, on_s9;
	logic        err_s9;

	// stage 1: range checks and fold products
	ijust_pkg::action_t act_in;
	logic               days_ok, mon_full_ok, mon_days_ok, err_in;
	logic signed [17:0] days_n;
	logic signed [12:0] mon_n;
	logic signed [49:0] dprod_w, mprod_w;
	logic [63:0]        m30_w, dext_w, mext_w;

	always_comb begin
		act_in      = ijust_pkg::action_t'(action);
		days_ok     = (in_days <= ijust_pkg::DAY_LIM) && (in_days >= -ijust_pkg::DAY_LIM);
		mon_full_ok = (in_months <= ijust_pkg::MONTH_LIM) &&
			(in_months >= -ijust_pkg::MONTH_LIM);
		mon_days_ok = (in_months <= ijust_pkg::M30_LIM) && (in_months >= -ijust_pkg::M30_LIM);
		days_n      = in_days[17:0];
		mon_n       = in_months[12:0];
		dprod_w     = 50'(days_n) * 50'(ijust_pkg::DAY_K);
		mprod_w     = 50'(mon_n) * 50'(ijust_pkg::MONTH_K);
		// times thirty
		m30_w       = (in_months <<< 5) - (in_months <<< 1);
		dext_w      = 64'(dprod_w[47:0]) << ijust_pkg::DAY_SHIFT;
		mext_w      = (act_in == ijust_pkg::ACT_FULL) ?
			(64'(mprod_w[47:0]) << ijust_pkg::DAY_SHIFT) : m30_w;
		case (act_in)
			ijust_pkg::ACT_HOURS: err_in = !days_ok;
			ijust_pkg::ACT_DAYS:  err_in = !mon_days_ok;
			ijust_pkg::ACT_FULL:  err_in = !mon_full_ok || !days_ok;
			default:              err_in = 1'b0;
		endcase
	end

	// stage 2: first checked add
	logic [63:0] opa_w, opb_w, sum_w;
	logic        ovf2_w;

	always_comb begin
		case (act_s1)
			ijust_pkg::ACT_HOURS: begin
				opa_w = ivl_s1.nanos;
				opb_w = dprod_s1;
			end
			ijust_pkg::ACT_DAYS: begin
				opa_w = mprod_s1;
				opb_w = ivl_s1.days;
			end
			ijust_pkg::ACT_FULL: begin
				opa_w = mprod_s1;
				opb_w = dprod_s1;
			end
			default: begin
				opa_w = '0;
				opb_w = '0;
			end
		endcase
		sum_w  = opa_w + opb_w;
		ovf2_w = (opa_w[63] == opb_w[63]) && (sum_w[63] != opa_w[63]);
	end

	// stage 3: nanos added last in the full fold
	logic [63:0] t_w;
	logic        ovf3_w;

	always_comb begin
		if (act_s2 == ijust_pkg::ACT_FULL) begin
			t_w    = sum_s2 + ivl_s2.nanos;
			ovf3_w = (sum_s2[63] == ivl_s2.nanos[63]) && (t_w[63] != sum_s2[63]);
		end else begin
			t_w    = sum_s2;
			ovf3_w = 1'b0;
		end
	end

	// stage 5: quotient estimate by a day, top digit by thirty
	logic [47:0] est_w;

	always_comb begin
		est_w = 48'(mag_s4[63:36]) * 48'(ijust_pkg::DAY_RECIP);
	end

	// stage 6: remainder of the estimate
	logic [47:0] back_w, diff_w;

	always_comb begin
		back_w = 48'(qe_s5) * 48'(ijust_pkg::DAY_K);
		diff_w = mag_s5[63:16] - back_w;
	end

	// stage 7: one correction step
	logic [16:0] qd_w;
	logic [30:0] nrem_w;

	always_comb begin
		if (rem_s6 >= 32'(ijust_pkg::DAY_K)) begin
			qd_w   = qd_s6 + 17'd1;
			nrem_w = 31'(rem_s6 - 32'(ijust_pkg::DAY_K));
		end else begin
			qd_w   = qd_s6;
			nrem_w = rem_s6[30:0];
		end
	end

	// stage 8: last digit by thirty, shared by the days and full folds
	logic [20:0]       v8_w;
	ijust_pkg::div30_t c0_w;
	logic [63:0]       mmag_w, dmag_w;

	always_comb begin
		v8_w = (act_s7 == ijust_pkg::ACT_DAYS) ? {c1_s7.rem, lo_s7} : 21'(qd_s7);
		c0_w = ijust_pkg::div30(v8_w);
		if (act_s7 == ijust_pkg::ACT_DAYS) begin
			mmag_w = {c3_s7.quo, c2_s7.quo, c1_s7.quo, c0_w.quo};
		end else begin
			mmag_w = 64'(c0_w.quo);
		end
		if (act_s7 == ijust_pkg::ACT_HOURS) begin
			dmag_w = 64'(qd_s7);
		end else begin
			dmag_w = 64'(c0_w.rem);
		end
	end

	// stage 9: sign, pass-through and error zeroing
	logic [63:0] msg_w, dsg_w, nsg_w, om_w, od_w, on_w;

	always_comb begin
		msg_w = neg_s8 ? (64'd0 - mmag_s8) : mmag_s8;
		dsg_w = neg_s8 ? (64'd0 - dmag_s8) : dmag_s8;
		nsg_w = neg_s8 ? (64'd0 - nmag_s8) : nmag_s8;
		case (act_s8)
			ijust_pkg::ACT_HOURS: begin
				om_w = ivl_s8.months;
				od_w = dsg_w;
				on_w = nsg_w;
			end
			ijust_pkg::ACT_DAYS: begin
				om_w = msg_w;
				od_w = dsg_w;
				on_w = ivl_s8.nanos;
			end
			ijust_pkg::ACT_FULL: begin
				om_w = msg_w;
				od_w = dsg_w;
				on_w = nsg_w;
			end
			default: begin
				om_w = ivl_s8.months;
				od_w = ivl_s8.days;
				on_w = ivl_s8.nanos;
			end
		endcase
		if (err_s8) begin
			om_w = '0;
			od_w = '0;
			on_w = '0;
		end
	end

	// whole pipe holds while a result waits at the output
	assign en       = !(v_s9 && out_stall);
	assign in_stall = v_s9 && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			act_s1        <= act_in;
			ivl_s1.months <= in_months;
			ivl_s1.days   <= in_days;
			ivl_s1.nanos  <= in_nanos;
			err_s1        <= err_in;
			dprod_s1      <= dext_w;
			mprod_s1      <= mext_w;

			act_s2 <= act_s1;
			ivl_s2 <= ivl_s1;
			err_s2 <= err_s1 || ovf2_w;
			sum_s2 <= sum_w;

			act_s3 <= act_s2;
			ivl_s3 <= ivl_s2;
			err_s3 <= err_s2 || ovf3_w;
			t_s3   <= t_w;

			act_s4 <= act_s3;
			ivl_s4 <= ivl_s3;
			err_s4 <= err_s3;
			neg_s4 <= t_s3[63];
			mag_s4 <= t_s3[63] ? (64'd0 - t_s3) : t_s3;

			act_s5 <= act_s4;
			ivl_s5 <= ivl_s4;
			err_s5 <= err_s4;
			neg_s5 <= neg_s4;
			mag_s5 <= mag_s4;
			qe_s5  <= est_w[46:30];
			c3_s5  <= ijust_pkg::div30(21'(mag_s4[63:48]));

			act_s6 <= act_s5;
			ivl_s6 <= ivl_s5;
			err_s6 <= err_s5;
			neg_s6 <= neg_s5;
			qd_s6  <= qe_s5;
			rem_s6 <= diff_w[31:0];
			lo_s6  <= mag_s5[31:0];
			c3_s6  <= c3_s5;
			c2_s6  <= ijust_pkg::div30({c3_s5.rem, mag_s5[47:32]});

			act_s7  <= act_s6;
			ivl_s7  <= ivl_s6;
			err_s7  <= err_s6;
			neg_s7  <= neg_s6;
			qd_s7   <= qd_w;
			nrem_s7 <= nrem_w;
			lo_s7   <= lo_s6[15:0];
			c3_s7   <= c3_s6;
			c2_s7   <= c2_s6;
			c1_s7   <= ijust_pkg::div30({c2_s6.rem, lo_s6[31:16]});

			act_s8  <= act_s7;
			ivl_s8  <= ivl_s7;
			err_s8  <= err_s7;
			neg_s8  <= neg_s7;
			mmag_s8 <= mmag_w;
			dmag_s8 <= dmag_w;
			nmag_s8 <= 64'({nrem_s7, lo_s7});

			om_s9  <= om_w;
			od_s9  <= od_w;
			on_s9  <= on_w;
			err_s9 <= err_s8;
		end
	end

	assign out_valid   = v_s9;
	assign out_months  = om_s9;
	assign out_days    = od_s9;
	assign out_nanos   = on_s9;
	assign range_error = err_s9;

`ifndef SYNTHESIS
	// an overflowed fold never leaks partial fields
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && range_error |-> out_months == '0 && out_days == '0 && out_nanos == '0)
		else $error("range error item with nonzero fields");

	// the day quotient estimate needs at most one correction
	assert property (@(posedge clk) disable iff (!arst_n)
		v_s7 |-> nrem_s7 < 31'(ijust_pkg::DAY_K))
		else $error("nanosecond remainder not below one day");

	// day remainder after the split by thirty stays below a month
	assert property (@(posedge clk) disable iff (!arst_n)
		v_s8 && (act_s8 == ijust_pkg::ACT_DAYS || act_s8 == ijust_pkg::ACT_FULL)
		|-> dmag_s8 < 64'(ijust_pkg::MONTH_DAYS))
		else $error("day remainder not below a month");
`endif

endmodule

>>> test/interval_justify_unit_test.sv
// ----------------------------------------------------------------------------
// interval_justify_unit_test: self-checking bench for the interval normalizer
// A queue of directed and random intervals feeds a valid/stall driver; a
// monitor predicts each accepted item in 128-bit arithmetic, queues the
// expected months/days/nanos/range_error and compares every result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module interval_justify_unit_test;

	typedef struct {
		ijust_pkg::action_t act;
		logic signed [63:0] months;
		logic signed [63:0] days;
		logic signed [63:0] nanos;
	} interval_item_t;

	typedef struct {
		logic signed [63:0] months;
		logic signed [63:0] days;
		logic signed [63:0] nanos;
		logic               err;
	} justified_t;

	localparam logic signed [63:0] I64_MAX        = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] I64_MIN        = 64'sh8000_0000_0000_0000;
	localparam logic signed [63:0] NS_PER_DAY     = 64'sd86400000000000;
	localparam logic signed [63:0] DAYS_PER_MONTH = 64'sd30;
	localparam logic signed [63:0] NS_PER_MONTH   = NS_PER_DAY * DAYS_PER_MONTH;
	localparam logic signed [63:0] DAY_LIMIT      = I64_MAX / NS_PER_DAY;
	localparam logic signed [63:0] M30_LIMIT      = I64_MAX / DAYS_PER_MONTH;
	localparam logic signed [63:0] MONTH_LIMIT    = I64_MAX / NS_PER_MONTH;
	localparam int RANDOM_ITEMS   = 680;
	localparam int TAIL_CYCLES    = 20;
	localparam int WATCHDOG_LIMIT = 1000;

	logic               clk         = 1'b0;
	logic               arst_n      = 1'b0;
	logic               in_valid    = 1'b0;
	logic               in_stall;
	logic [1:0]         action      = 2'd0;
	logic signed [63:0] in_months   = '0;
	logic signed [63:0] in_days     = '0;
	logic signed [63:0] in_nanos    = '0;
	logic               out_valid;
	logic               out_stall   = 1'b0;
	logic signed [63:0] out_months;
	logic signed [63:0] out_days;
	logic signed [63:0] out_nanos;
	logic               range_error;

	interval_item_t pending_items[$];
	justified_t     expected_results[$];
	interval_item_t cur_item;

	logic in_fire  = 1'b0;
	logic out_fire = 1'b0;
	logic next_valid;
	int   tx_gap   = 0;
	int   tx_quiet = 0;
	int   rx_stall = 0;
	int   rx_quiet = 0;
	int   idle_cycles = 0;
	int   mismatches  = 0;
	int   overflow_items = 0;
	int   act_seen[4] = '{0, 0, 0, 0};

	interval_justify_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.action      (action),
		.in_months   (in_months),
		.in_days     (in_days),
		.in_nanos    (in_nanos),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_months  (out_months),
		.out_days    (out_days),
		.out_nanos   (out_nanos),
		.range_error (range_error)
	);

	always #5 clk = ~clk;

	function automatic logic fits64(logic signed [127:0] v);
		return v[127:63] == {65{v[63]}};
	endfunction

	// fold, check every step for 64-bit overflow, then split the magnitude
	function automatic justified_t justify_interval(ijust_pkg::action_t act,
			logic signed [63:0] m, logic signed [63:0] d, logic signed [63:0] n);
		logic signed [127:0] mw, dw, nw, prod_m, prod_d, sum;
		logic [63:0] mag, rem;
		logic        neg, ovf;
		justified_t  r;
		mw = m;
		dw = d;
		nw = n;
		r.months = m;
		r.days = d;
		r.nanos = n;
		r.err = 1'b0;
		ovf = 1'b0;
		sum = '0;
		case (act)
			ijust_pkg::ACT_HOURS: begin
				prod_d = dw * NS_PER_DAY;
				sum = nw + prod_d;
				ovf = !fits64(prod_d) || !fits64(sum);
			end
			ijust_pkg::ACT_DAYS: begin
				prod_m = mw * DAYS_PER_MONTH;
				sum = prod_m + dw;
				ovf = !fits64(prod_m) || !fits64(sum);
			end
			ijust_pkg::ACT_FULL: begin
				prod_m = mw * NS_PER_MONTH;
				prod_d = dw * NS_PER_DAY;
				sum = prod_m + prod_d;
				ovf = !fits64(prod_m) || !fits64(prod_d) || !fits64(sum);
				sum = sum + nw;
				ovf = ovf || !fits64(sum);
			end
			default: ;
		endcase
		if (ovf) begin
			r.months = '0;
			r.days = '0;
			r.nanos = '0;
			r.err = 1'b1;
		end else if (act != ijust_pkg::ACT_PASS) begin
			neg = sum[63];
			// most negative total keeps its unsigned magnitude of 2^63
			mag = neg ? -sum[63:0] : sum[63:0];
			case (act)
				ijust_pkg::ACT_HOURS: begin
					r.days  = neg ? -(mag / NS_PER_DAY) : mag / NS_PER_DAY;
					r.nanos = neg ? -(mag % NS_PER_DAY) : mag % NS_PER_DAY;
				end
				ijust_pkg::ACT_DAYS: begin
					r.months = neg ? -(mag / DAYS_PER_MONTH) : mag / DAYS_PER_MONTH;
					r.days   = neg ? -(mag % DAYS_PER_MONTH) : mag % DAYS_PER_MONTH;
				end
				default: begin
					rem = mag % NS_PER_MONTH;
					r.months = neg ? -(mag / NS_PER_MONTH) : mag / NS_PER_MONTH;
					r.days   = neg ? -(rem / NS_PER_DAY) : rem / NS_PER_DAY;
					r.nanos  = neg ? -(rem % NS_PER_DAY) : rem % NS_PER_DAY;
				end
			endcase
		end
		return r;
	endfunction

	function automatic void add_item(ijust_pkg::action_t a, logic signed [63:0] m,
			logic signed [63:0] d, logic signed [63:0] n);
		interval_item_t it;
		it.act = a;
		it.months = m;
		it.days = d;
		it.nanos = n;
		pending_items.insert(pending_items.size(), it);
	endfunction

	// random value of random bit length, either sign
	function automatic logic signed [63:0] rand_span(int lo, int hi);
		logic signed [63:0] v;
		v = {$urandom, $urandom};
		return v >>> $urandom_range(hi, lo);
	endfunction

	function automatic interval_item_t random_item();
		interval_item_t it;
		if ($urandom_range(3, 0) == 0) begin
			it.act = ijust_pkg::action_t'($urandom_range(3, 0));
			it.months = {$urandom, $urandom};
			it.days = {$urandom, $urandom};
			it.nanos = {$urandom, $urandom};
		end else begin
			it.act = ijust_pkg::action_t'($urandom_range(2, 0));
			case (it.act)
				ijust_pkg::ACT_HOURS: begin
					it.months = rand_span(0, 63);
					it.days = rand_span(46, 63);
					it.nanos = rand_span(0, 63);
				end
				ijust_pkg::ACT_DAYS: begin
					it.months = rand_span(5, 63);
					it.days = rand_span(0, 63);
					it.nanos = rand_span(0, 63);
				end
				default: begin
					it.months = rand_span(52, 63);
					it.days = rand_span(47, 63);
					it.nanos = rand_span(1, 63);
				end
			endcase
		end
		return it;
	endfunction

	// idle length per item, with occasional runs of back-to-back items
	function automatic int draw_wait(ref int quiet_left);
		if (quiet_left > 0) begin
			quiet_left--;
			return 0;
		end
		if ($urandom_range(15, 0) == 0) begin
			quiet_left = $urandom_range(40, 10);
			return 0;
		end
		return $urandom_range(12, 0);
	endfunction

	task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0d, got %0d", name, $signed(exp_v), $signed(act_v));
			mismatches++;
		end
	endtask

	// driver: new inputs at the falling edge, payload held while stalled
	always @(negedge clk) begin
		if (arst_n) begin
			next_valid = in_valid && !in_fire;
			if (!next_valid) begin
				if (tx_gap > 0) begin
					tx_gap--;
				end else if (pending_items.size() != 0) begin
					cur_item = pending_items.pop_front();
					action <= cur_item.act;
					in_months <= cur_item.months;
					in_days <= cur_item.days;
					in_nanos <= cur_item.nanos;
					next_valid = 1'b1;
					tx_gap = draw_wait(tx_quiet);
				end
			end
			in_valid <= next_valid;
			if (out_fire)
				rx_stall = draw_wait(rx_quiet);
			if (rx_stall > 0) begin
				out_stall <= 1'b1;
				rx_stall--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// monitor: results checked before the same edge's input is predicted
	always @(posedge clk) begin
		justified_t exp_r;
		if (arst_n) begin
			in_fire <= in_valid && !in_stall;
			out_fire <= out_valid && !out_stall;
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$error("result with no item outstanding: months %0d days %0d nanos %0d",
						out_months, out_days, out_nanos);
					mismatches++;
				end else begin
					exp_r = expected_results.pop_front();
					check_field("out_months", exp_r.months, out_months);
					check_field("out_days", exp_r.days, out_days);
					check_field("out_nanos", exp_r.nanos, out_nanos);
					check_field("range_error", 64'(exp_r.err), 64'(range_error));
				end
			end
			if (in_valid && !in_stall) begin
				exp_r = justify_interval(ijust_pkg::action_t'(action), in_months, in_days,
					in_nanos);
				expected_results.insert(expected_results.size(), exp_r);
				act_seen[action]++;
				if (exp_r.err)
					overflow_items++;
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				idle_cycles <= 0;
			end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
				$display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
				$display("Test completed with failures");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		// zero and boundary totals for each mode
		add_item(ijust_pkg::ACT_HOURS, 64'sd0, 64'sd0, 64'sd0);
		add_item(ijust_pkg::ACT_HOURS, I64_MAX, 64'sd1, NS_PER_DAY - 1);
		add_item(ijust_pkg::ACT_HOURS, I64_MIN, -64'sd1, 64'sd1);
		add_item(ijust_pkg::ACT_HOURS, 64'sd7, DAY_LIMIT, I64_MAX - DAY_LIMIT * NS_PER_DAY);
		add_item(ijust_pkg::ACT_HOURS, 64'sd0, DAY_LIMIT + 1, 64'sd0);
		add_item(ijust_pkg::ACT_HOURS, 64'sd0, I64_MIN, 64'sd0);
		add_item(ijust_pkg::ACT_HOURS, 64'sd0, 64'sd0, I64_MIN);
		add_item(ijust_pkg::ACT_HOURS, 64'sd0, DAY_LIMIT, I64_MAX);
		add_item(ijust_pkg::ACT_DAYS, 64'sd0, 64'sd0, 64'sd0);
		add_item(ijust_pkg::ACT_DAYS, 64'sd1, -64'sd31, I64_MAX);
		add_item(ijust_pkg::ACT_DAYS, M30_LIMIT, I64_MAX - M30_LIMIT * DAYS_PER_MONTH,
			64'sd5);
		add_item(ijust_pkg::ACT_DAYS, M30_LIMIT + 1, 64'sd0, 64'sd0);
		add_item(ijust_pkg::ACT_DAYS, I64_MIN, 64'sd0, 64'sd0);
		add_item(ijust_pkg::ACT_DAYS, 64'sd0, I64_MIN, I64_MIN);
		add_item(ijust_pkg::ACT_DAYS, M30_LIMIT, I64_MAX, I64_MIN);
		add_item(ijust_pkg::ACT_FULL, 64'sd0, 64'sd0, 64'sd0);
		add_item(ijust_pkg::ACT_FULL, -64'sd1, 64'sd1, 64'sd1);
		add_item(ijust_pkg::ACT_FULL, MONTH_LIMIT, 64'sd0,
			I64_MAX - MONTH_LIMIT * NS_PER_MONTH);
		add_item(ijust_pkg::ACT_FULL, MONTH_LIMIT + 1, 64'sd0, 64'sd0);
		add_item(ijust_pkg::ACT_FULL, 64'sd0, DAY_LIMIT + 1, 64'sd0);
		// months and days together overflow, the nanos would bring it back
		add_item(ijust_pkg::ACT_FULL, MONTH_LIMIT,
			(I64_MAX - MONTH_LIMIT * NS_PER_MONTH) / NS_PER_DAY + 1, -(64'sd1 <<< 62));
		add_item(ijust_pkg::ACT_FULL, 64'sd0, 64'sd0, I64_MIN);
		add_item(ijust_pkg::ACT_FULL, I64_MAX, I64_MAX, I64_MAX);
		add_item(ijust_pkg::ACT_PASS, I64_MIN, I64_MAX, -64'sd1);
		add_item(ijust_pkg::ACT_PASS, I64_MAX, I64_MIN, 64'sd0);
		for (int i = 0; i < RANDOM_ITEMS; i++)
			pending_items.insert(pending_items.size(), random_item());

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_items.size() != 0 || in_valid)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("justified %0d hours, %0d days, %0d whole and %0d pass-through items",
			act_seen[ijust_pkg::ACT_HOURS], act_seen[ijust_pkg::ACT_DAYS],
			act_seen[ijust_pkg::ACT_FULL], act_seen[ijust_pkg::ACT_PASS]);
		$display("%0d items overflowed the fold, %0d field mismatches", overflow_items,
			mismatches);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
